// ===== hw/rtl/signed_unsigned_divider_64_assert.svh =====
// Assertion macros for the restoring divider.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SIGNED_UNSIGNED_DIVIDER_64_ASSERT_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("divider assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SUD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("divider assertion failed");

`endif

// ===== hw/rtl/sud_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider package
// Word types of the two channels and the sign control carried down the chain.
// ----------------------------------------------------------------------------
package sud_pkg;

    // Width of the fields on the ports; the working width may be smaller.
    localparam int PORT_WIDTH = 64;

    // Division modes carried in the cmd field.
    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [PORT_WIDTH-1:0] dividend;
        logic [PORT_WIDTH-1:0] divisor;
    } t_sud_in;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] quotient;
        logic [PORT_WIDTH-1:0] remainder;
    } t_sud_out;

    // Sign corrections to apply once the magnitudes have been divided.
    typedef struct packed {
        logic neg_q;
        logic neg_r;
    } t_sud_sign;

endpackage
`default_nettype wire

// ===== hw/rtl/sud_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider operand stage
// Takes the absolute values in signed mode and records the sign corrections.
// ----------------------------------------------------------------------------
module sud_prep
    import sud_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_sud_in               i_word,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_nq,
    output logic [DATA_WIDTH-1:0]      o_den,
    output t_sud_sign                  o_sign
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_nq;
    logic [DATA_WIDTH-1:0] r_den;
    t_sud_sign             r_sign;

    logic [DATA_WIDTH-1:0] n_nq;
    logic [DATA_WIDTH-1:0] n_den;
    t_sud_sign             n_sign;
    logic                  a_neg;
    logic                  b_neg;

    always_comb begin
        a_neg = (i_word.cmd == CMD_SIGNED) && i_word.dividend[DATA_WIDTH-1];
        b_neg = (i_word.cmd == CMD_SIGNED) && i_word.divisor[DATA_WIDTH-1];
        n_nq  = a_neg ? (DATA_WIDTH'(0) - i_word.dividend[DATA_WIDTH-1:0])
                      : i_word.dividend[DATA_WIDTH-1:0];
        n_den = b_neg ? (DATA_WIDTH'(0) - i_word.divisor[DATA_WIDTH-1:0])
                      : i_word.divisor[DATA_WIDTH-1:0];
        n_sign.neg_q = a_neg ^ b_neg;
        n_sign.neg_r = a_neg;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_nq   <= n_nq;
            r_den  <= n_den;
            r_sign <= n_sign;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = '0;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_sign  = r_sign;

endmodule
`default_nettype wire

// ===== hw/rtl/sud_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider cell
// One restoring shift-subtract step, producing one quotient bit.
// ----------------------------------------------------------------------------
module sud_cell
    import sud_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_nq,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    input  wire t_sud_sign             i_sign,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_nq,
    output logic [DATA_WIDTH-1:0]      o_den,
    output t_sud_sign                  o_sign
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_nq;
    logic [DATA_WIDTH-1:0] r_den;
    t_sud_sign             r_sign;

    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH+1:0] diff;
    logic                  ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_nq;

    // The shifted partial remainder keeps its carry bit, so a subtraction is
    // taken whenever the borrow out of the extended difference is clear.
    always_comb begin
        rem_sh = {i_rem, i_nq[DATA_WIDTH-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_den};
        ge     = !diff[DATA_WIDTH+1];
        n_rem  = ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        n_nq   = {i_nq[DATA_WIDTH-2:0], ge};
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_den  <= i_den;
            r_sign <= i_sign;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_sign  = r_sign;

endmodule
`default_nettype wire

// ===== hw/rtl/sud_fix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider result stage
// Applies the sign corrections and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module sud_fix
    import sud_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_nq,
    input  wire t_sud_sign             i_sign,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_sud_out                   o_word
);

    logic     r_valid;
    t_sud_out r_word;
    t_sud_out n_word;

    always_comb begin
        n_word = '0;
        n_word.quotient[DATA_WIDTH-1:0] =
            i_sign.neg_q ? (DATA_WIDTH'(0) - i_nq) : i_nq;
        n_word.remainder[DATA_WIDTH-1:0] =
            i_sign.neg_r ? (DATA_WIDTH'(0) - i_rem) : i_rem;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== hw/rtl/signed_unsigned_divider_64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed and unsigned restoring divider
// Pipelined shift-subtract divider built as a chain of one-bit cells.
// ----------------------------------------------------------------------------
// Usage: the sender presents a word (cmd, dividend, divisor) with i_valid and
// it is taken on a rising edge where o_stall is low. cmd selects unsigned or
// signed two's complement division. The result word (quotient, remainder)
// leaves on o_valid and is taken on a rising edge where i_stall is low.
// A word passes through the operand stage, the chain of DATA_WIDTH cells (one
// per quotient bit) and the sign correction stage that also serves as the
// output register. Throughput is one word per cycle while the receiver does
// not stall, as each cell is its own pipeline stage with its own subtractor.
// A signed quotient is negated when the operand signs differ and the
// remainder takes the dividend's sign. Dividing by zero gives an all-ones raw
// quotient and the dividend magnitude as raw remainder, before sign fixes.
// When the receiver stalls, only stages that hold a word freeze; empty
// stages still fill, so words keep being taken until the chain is full.
// Synchronous reset clears every stage's valid bit; nothing else needs it.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_64
    import sud_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_sud_in  i_word,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_sud_out      o_word
);

    // Stage k of these arrays is the output of the operand stage (k = 0) or
    // of cell k-1; the last entry feeds the result stage.
    logic                  stg_valid [0:DATA_WIDTH];
    logic                  stg_stall [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] stg_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] stg_nq    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] stg_den   [0:DATA_WIDTH];
    t_sud_sign             stg_sign  [0:DATA_WIDTH];

    // The operand stage starts each word with a zero partial remainder and
    // the dividend magnitude in the shifting quotient register.
    sud_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (stg_valid[0]),
        .i_stall (stg_stall[0]),
        .o_rem   (stg_rem[0]),
        .o_nq    (stg_nq[0]),
        .o_den   (stg_den[0]),
        .o_sign  (stg_sign[0])
    );

    // Each cell shifts in one dividend bit and produces one quotient bit.
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
        sud_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_stall (stg_stall[k]),
            .i_rem   (stg_rem[k]),
            .i_nq    (stg_nq[k]),
            .i_den   (stg_den[k]),
            .i_sign  (stg_sign[k]),
            .o_valid (stg_valid[k+1]),
            .i_stall (stg_stall[k+1]),
            .o_rem   (stg_rem[k+1]),
            .o_nq    (stg_nq[k+1]),
            .o_den   (stg_den[k+1]),
            .o_sign  (stg_sign[k+1])
        );
    end

    // The divisor is no longer needed once the last cell has run.
    sud_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[DATA_WIDTH]),
        .o_stall (stg_stall[DATA_WIDTH]),
        .i_rem   (stg_rem[DATA_WIDTH]),
        .i_nq    (stg_nq[DATA_WIDTH]),
        .i_sign  (stg_sign[DATA_WIDTH]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

`include "signed_unsigned_divider_64_assert.svh"

    // With the output register empty nothing in the chain may hold back.
    `SUD_ASSERT_NOW(a_empty_out_no_stall, !o_valid, !o_stall)
    // A word leaving the operand stage must arrive in the first cell.
    `SUD_ASSERT_NEXT(a_prep_to_cell, stg_valid[0] && !stg_stall[0], stg_valid[1])
    // A word leaving the last cell must land in the output register.
    `SUD_ASSERT_NEXT(a_cell_to_out, stg_valid[DATA_WIDTH] && !stg_stall[DATA_WIDTH],
        o_valid)

endmodule
`default_nettype wire

// ===== test/tb_signed_unsigned_divider_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed and unsigned restoring divider
// A queue of operand words feeds a clocked driver and a clocked monitor checks
// every result word against a bit-level model of restoring division, with
// random idling on the sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
module tb_signed_unsigned_divider_64;
    import sud_pkg::*;

    // Working width of the divider under test; the ports stay 64 bits wide.
    localparam int DW = 64;

    // Interesting operand patterns at the working width.
    localparam logic [63:0] V_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [63:0] V_ONE     = 64'h0000_0000_0000_0001;
    localparam logic [63:0] V_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] V_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] V_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int RANDOM_PER_PHASE = 175;
    // The chain is DW + 2 stages deep, so this comfortably covers the latency.
    localparam int DRAIN_CYCLES     = DW + 20;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_sud_in  i_word  = '0;
    logic     o_stall;
    logic     o_valid;
    t_sud_out o_word;

    // Words waiting to be presented, and results owed by the divider.
    t_sud_in  operands_pending[$];
    t_sud_out quot_rem_due[$];

    int n_queued      = 0;
    int n_taken       = 0;
    int n_errors      = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    signed_unsigned_divider_64 #(
        .DATA_WIDTH(DW)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word (i_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word (o_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Expected quotient and remainder for one operand word. The magnitudes are
    // divided one bit at a time, keeping a partial remainder one bit wider than
    // the operands so that a divisor with its top bit set still divides
    // properly. Dividing by zero falls out of the same loop: every step
    // subtracts nothing and sets its quotient bit, and the remainder ends up
    // as the dividend magnitude.
    function automatic t_sud_out divide_word(t_sud_in w);
        logic [DW-1:0] mag_a;
        logic [DW-1:0] mag_b;
        logic [DW-1:0] quo;
        logic [DW-1:0] rem;
        logic [DW:0]   part;
        logic          flip_q;
        logic          flip_r;
        t_sud_out      res;
        mag_a  = w.dividend[DW-1:0];
        mag_b  = w.divisor[DW-1:0];
        flip_q = 1'b0;
        flip_r = 1'b0;
        // In signed mode the operands become magnitudes first. The most
        // negative pattern negates to itself and is then read unsigned.
        if (w.cmd == CMD_SIGNED) begin
            if (mag_a[DW-1]) begin
                flip_q = 1'b1;
                flip_r = 1'b1;
                mag_a  = '0 - mag_a;
            end
            if (mag_b[DW-1]) begin
                flip_q = ~flip_q;
                mag_b  = '0 - mag_b;
            end
        end
        quo = '0;
        rem = '0;
        for (int bit_i = DW - 1; bit_i >= 0; bit_i--) begin
            part = {rem, mag_a[bit_i]};
            if (part >= {1'b0, mag_b}) begin
                part       = part - {1'b0, mag_b};
                quo[bit_i] = 1'b1;
            end
            rem = part[DW-1:0];
        end
        // Sign fixes wrap modulo the working width, so MIN / -1 stays MIN.
        if (flip_q) begin
            quo = '0 - quo;
        end
        if (flip_r) begin
            rem = '0 - rem;
        end
        res = '0;
        res.quotient[DW-1:0]  = quo;
        res.remainder[DW-1:0] = rem;
        return res;
    endfunction

    // A random operand, biased towards the corners: small magnitudes, small
    // negatives, values with their leading bits cleared, and the edge patterns.
    function automatic logic [63:0] random_operand();
        logic [63:0] val;
        case ($urandom_range(7))
            3: begin
                val = 64'($urandom_range(255));
            end
            4: begin
                val = V_ZERO - 64'($urandom_range(255, 1));
            end
            5: begin
                val = {$urandom, $urandom} >> $urandom_range(63);
            end
            6: begin
                case ($urandom_range(5))
                    0:       val = V_ZERO;
                    1:       val = V_ONE;
                    2:       val = V_ONES;
                    3:       val = V_MIN;
                    4:       val = V_MIN + V_ONE;
                    default: val = V_MAX_POS;
                endcase
            end
            7: begin
                val = {$urandom, $urandom} | V_MIN;
            end
            default: begin
                val = {$urandom, $urandom};
            end
        endcase
        return val;
    endfunction

    task automatic queue_division(input logic mode, input logic [63:0] num,
                                  input logic [63:0] den);
        t_sud_in w;
        w.cmd      = mode;
        w.dividend = num;
        w.divisor  = den;
        operands_pending.push_back(w);
        n_queued++;
    endtask

    task automatic queue_random_divisions(input int count);
        for (int k = 0; k < count; k++) begin
            queue_division(logic'($urandom_range(1)), random_operand(), random_operand());
        end
    endtask

    // Waits, on falling edges so as to stay clear of the clocked blocks, until
    // every queued word has been taken by the divider.
    task automatic wait_all_taken();
        while (n_taken != n_queued) begin
            @(negedge i_clk);
        end
    endtask

    // Driver. A word that has been presented is held, untouched, until the
    // edge that takes it; its prediction is queued at that same edge. Only
    // then is the next word, or an idle cycle, chosen.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                quot_rem_due.push_back(divide_word(i_word));
                n_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (operands_pending.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_word  <= operands_pending.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, redrawn every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor. Every word taken from the output is compared with the oldest
    // outstanding prediction; a word with nothing outstanding is an error.
    always @(posedge i_clk) begin
        t_sud_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (quot_rem_due.size() == 0) begin
                $error("unexpected result word: quotient %h remainder %h",
                       o_word.quotient, o_word.remainder);
                n_errors++;
            end else begin
                want = quot_rem_due.pop_front();
                if (o_word.quotient !== want.quotient) begin
                    $error("quotient mismatch: expected %h, got %h",
                           want.quotient, o_word.quotient);
                    n_errors++;
                end
                if (o_word.remainder !== want.remainder) begin
                    $error("remainder mismatch: expected %h, got %h",
                           want.remainder, o_word.remainder);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus and phases.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one, no idling on either side: directed corners, then random.
        send_idle_pct = 0;
        stall_pct     = 0;
        // Unsigned corners, including divide by zero and a divisor with its
        // top bit set.
        queue_division(CMD_UNSIGNED, V_ZERO, V_ZERO);
        queue_division(CMD_UNSIGNED, V_ONES, V_ZERO);
        queue_division(CMD_UNSIGNED, V_ONES, V_ONE);
        queue_division(CMD_UNSIGNED, V_ONES, V_ONES);
        queue_division(CMD_UNSIGNED, V_ONE, V_ONES);
        queue_division(CMD_UNSIGNED, V_ONES, V_MIN);
        queue_division(CMD_UNSIGNED, V_MIN, V_ONES);
        queue_division(CMD_UNSIGNED, 64'd12345, 64'd7);
        // Signed: every sign combination, the most negative value in each
        // position, and divide by zero with either dividend sign.
        queue_division(CMD_SIGNED, 64'd7, 64'd2);
        queue_division(CMD_SIGNED, V_ZERO - 64'd7, 64'd2);
        queue_division(CMD_SIGNED, 64'd7, V_ZERO - 64'd2);
        queue_division(CMD_SIGNED, V_ZERO - 64'd7, V_ZERO - 64'd2);
        queue_division(CMD_SIGNED, V_MIN, V_ONES);
        queue_division(CMD_SIGNED, V_MIN, V_ONE);
        queue_division(CMD_SIGNED, V_MIN, V_MIN);
        queue_division(CMD_SIGNED, V_ZERO, V_MIN);
        queue_division(CMD_SIGNED, V_ONES, V_MIN);
        queue_division(CMD_SIGNED, V_MAX_POS, V_ONES);
        queue_division(CMD_SIGNED, V_ONE, V_ONES);
        queue_division(CMD_SIGNED, 64'd5, V_ZERO);
        queue_division(CMD_SIGNED, V_ZERO - 64'd5, V_ZERO);
        queue_division(CMD_SIGNED, V_MIN, V_ZERO);
        queue_division(CMD_SIGNED, V_ZERO, V_ZERO);
        queue_random_divisions(RANDOM_PER_PHASE);
        wait_all_taken();

        // Phase two: the sender idles about half of the time.
        send_idle_pct = 53;
        stall_pct     = 0;
        queue_random_divisions(RANDOM_PER_PHASE);
        wait_all_taken();

        // Phase three: the receiver stalls about half of the time.
        send_idle_pct = 0;
        stall_pct     = 53;
        queue_random_divisions(RANDOM_PER_PHASE);
        wait_all_taken();

        // Phase four: light idling on both sides.
        send_idle_pct = 13;
        stall_pct     = 13;
        queue_random_divisions(RANDOM_PER_PHASE);
        wait_all_taken();

        // Drain, then allow a pipeline's worth of cycles for any stray word.
        while (quot_rem_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("PASS signed_unsigned_divider_64");
        end else begin
            $display("FAIL signed_unsigned_divider_64");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #3_600_000;
        $display("FAIL signed_unsigned_divider_64");
        $finish;
    end

endmodule
